// File: sv/regex_infix_to_postfix_assert.svh
// Assertion macros for the infix-to-postfix regex converter.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef REGEX_INFIX_TO_POSTFIX_ASSERT_SVH
`define REGEX_INFIX_TO_POSTFIX_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RITP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ritp_pkg.sv
// Shared types and character constants for the regex infix-to-postfix converter.
// No dependencies.
package ritp_pkg;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  // Results one token can cause at most, and result queue depth.
  localparam int unsigned RUN_MAX  = 4;
  localparam int unsigned RQ_DEPTH = 8;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ILLEGAL = 3'd1,
    ERR_CLOSE   = 3'd2,
    ERR_NEWLINE = 3'd3,
    ERR_DEEP    = 3'd4
  } err_t;

  // Results caused by one accepted token, first result in slot 0.
  typedef struct packed {
    logic [2:0]       count;
    logic [3:0][7:0]  chars;
    err_t [3:0]       errs;
  } run_t;

  typedef struct packed {
    logic discarding;
    logic stack_top_pending;
  } conv_status_t;

endpackage

// File: sv/ritp_conv.sv
// Converter core: line state flags, top-of-stack register and the frame memory.
// Depends on ritp_pkg.
module ritp_conv #(
  parameter int unsigned MAX_NEST = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tok_fire,
  input  logic [7:0]            tok_char,
  output ritp_pkg::run_t        run,
  output ritp_pkg::conv_status_t status,
  output logic [$clog2(MAX_NEST+1)-1:0] depth
);

  localparam int unsigned DW = $clog2(MAX_NEST + 1);
  localparam int unsigned AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  logic [DW-1:0] depth_r, depth_nxt;
  logic          hpf_r, hpf_nxt;
  logic          up_r, up_nxt;
  logic          oc_r, oc_nxt;
  logic          disc_r, disc_nxt;
  // The top frame lives in top_r, or in rd_data_r right after a pop.
  logic [1:0]    top_r, top_nxt;
  logic          top_mem_r, top_mem_nxt;
  logic [1:0]    rd_data_r;
  logic [1:0]    top_eff;
  logic [1:0]    stack_mem [MAX_NEST];

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0]    wr_data;
  logic [2:0]    n;
  ritp_pkg::run_t r;
  logic          is_atom;

  assign top_eff = top_mem_r ? rd_data_r : top_r;
  assign is_atom = (tok_char == ritp_pkg::CH_SLASH) ||
                   (tok_char inside {[8'h30:8'h39]}) ||
                   (tok_char inside {[8'h61:8'h7A]});

  always_comb begin
    depth_nxt   = depth_r;
    hpf_nxt     = hpf_r;
    up_nxt      = up_r;
    oc_nxt      = oc_r;
    disc_nxt    = disc_r;
    top_nxt     = top_r;
    top_mem_nxt = top_mem_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = AW'(depth_r - 1'b1);
    rd_addr     = AW'(depth_r - 2'd2);
    wr_data     = top_eff;
    n           = 3'd0;
    r           = '0;

    if (disc_r) begin
      if (tok_char == ritp_pkg::CH_NL) begin
        disc_nxt  = 1'b0;
        depth_nxt = '0;
        hpf_nxt   = 1'b0;
        up_nxt    = 1'b0;
        oc_nxt    = 1'b0;
      end
    end else if (tok_char == ritp_pkg::CH_STAR) begin
      if (oc_r) begin
        r.chars[n[1:0]] = ritp_pkg::CH_STAR;
        n = n + 3'd1;
      end else begin
        r.errs[n[1:0]] = ritp_pkg::ERR_ILLEGAL;
        n = n + 3'd1;
        depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
        disc_nxt  = 1'b1;
      end
    end else if (tok_char == ritp_pkg::CH_PLUS) begin
      if (!oc_r) begin
        r.errs[n[1:0]] = ritp_pkg::ERR_ILLEGAL;
        n = n + 3'd1;
        depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
        disc_nxt  = 1'b1;
      end else begin
        if (hpf_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_DOT;
          n = n + 3'd1;
        end
        if (up_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_PLUS;
          n = n + 3'd1;
        end
        up_nxt  = 1'b1;
        hpf_nxt = 1'b0;
        oc_nxt  = 1'b0;
      end
    end else if (tok_char == ritp_pkg::CH_RPAR) begin
      if (!oc_r) begin
        r.errs[n[1:0]] = ritp_pkg::ERR_ILLEGAL;
        n = n + 3'd1;
        depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
        disc_nxt  = 1'b1;
      end else begin
        if (hpf_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_DOT;
          n = n + 3'd1;
        end
        if (up_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_PLUS;
          n = n + 3'd1;
        end
        if (depth_r != '0) begin
          depth_nxt = depth_r - 1'b1;
          hpf_nxt   = top_eff[0];
          up_nxt    = top_eff[1];
          oc_nxt    = 1'b1;
          // Fetch the frame below so it is ready as the next top.
          if (depth_r > DW'(1)) begin
            rd_en       = 1'b1;
            top_mem_nxt = 1'b1;
          end
        end else begin
          // A close with nothing open ends the line, then reports the error.
          r.chars[n[1:0]] = ritp_pkg::CH_NL;
          n = n + 3'd1;
          r.errs[n[1:0]] = ritp_pkg::ERR_NEWLINE;
          n = n + 3'd1;
          depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
          disc_nxt  = 1'b1;
        end
      end
    end else if (tok_char == ritp_pkg::CH_NL) begin
      if (!oc_r) begin
        if (depth_r != '0 || up_r || hpf_r) begin
          r.errs[n[1:0]] = ritp_pkg::ERR_ILLEGAL;
          n = n + 3'd1;
          depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
        end
      end else begin
        if (hpf_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_DOT;
          n = n + 3'd1;
        end
        if (up_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_PLUS;
          n = n + 3'd1;
        end
        if (depth_r != '0) begin
          r.errs[n[1:0]] = ritp_pkg::ERR_CLOSE;
          n = n + 3'd1;
        end else begin
          r.chars[n[1:0]] = ritp_pkg::CH_NL;
          n = n + 3'd1;
        end
        depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
      end
    end else if (is_atom || tok_char == ritp_pkg::CH_LPAR) begin
      if (oc_r) begin
        if (hpf_r) begin
          r.chars[n[1:0]] = ritp_pkg::CH_DOT;
          n = n + 3'd1;
        end
        hpf_nxt = 1'b1;
      end
      if (tok_char != ritp_pkg::CH_LPAR) begin
        r.chars[n[1:0]] = tok_char;
        n = n + 3'd1;
        oc_nxt = 1'b1;
      end else if (depth_r >= DW'(MAX_NEST)) begin
        r.errs[n[1:0]] = ritp_pkg::ERR_DEEP;
        n = n + 3'd1;
        depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
        disc_nxt  = 1'b1;
      end else begin
        // The old top spills to memory; the new frame becomes the top.
        wr_en       = (depth_r != '0);
        top_nxt     = {up_r, hpf_nxt};
        top_mem_nxt = 1'b0;
        depth_nxt   = depth_r + 1'b1;
        hpf_nxt     = 1'b0;
        up_nxt      = 1'b0;
        oc_nxt      = 1'b0;
      end
    end else begin
      if (oc_r && hpf_r) begin
        r.chars[n[1:0]] = ritp_pkg::CH_DOT;
        n = n + 3'd1;
      end
      r.errs[n[1:0]] = ritp_pkg::ERR_ILLEGAL;
      n = n + 3'd1;
      depth_nxt = '0; hpf_nxt = 1'b0; up_nxt = 1'b0; oc_nxt = 1'b0;
      disc_nxt  = 1'b1;
    end

    r.count = tok_fire ? n : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      hpf_r     <= 1'b0;
      up_r      <= 1'b0;
      oc_r      <= 1'b0;
      disc_r    <= 1'b0;
      top_mem_r <= 1'b0;
    end else if (tok_fire) begin
      depth_r   <= depth_nxt;
      hpf_r     <= hpf_nxt;
      up_r      <= up_nxt;
      oc_r      <= oc_nxt;
      disc_r    <= disc_nxt;
      top_mem_r <= top_mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_fire) begin
      top_r <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_fire && wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (tok_fire && rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  assign run                      = r;
  assign status.discarding        = disc_r;
  assign status.stack_top_pending = top_mem_r;
  assign depth                    = depth_r;

endmodule

// File: sv/ritp_rqueue.sv
// Result queue: takes up to four results per cycle, hands out one per beat.
// Depends on ritp_pkg.
module ritp_rqueue (
  input  logic           clk,
  input  logic           rst_n,
  input  ritp_pkg::run_t run,
  output logic           space_ok,
  output logic           q_valid,
  input  logic           q_ready,
  output logic [7:0]     q_char,
  output logic [2:0]     q_err,
  output logic           q_last,
  output logic [3:0]     q_count
);

  localparam int unsigned PW = $clog2(ritp_pkg::RQ_DEPTH);
  localparam int unsigned CW = $clog2(ritp_pkg::RQ_DEPTH + 1);

  logic [11:0]   q_mem [ritp_pkg::RQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign pop      = q_valid && q_ready;
  assign q_valid  = (count_r != '0);
  assign space_ok = (count_r <= CW'(ritp_pkg::RQ_DEPTH - ritp_pkg::RUN_MAX));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(run.count);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(run.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ritp_pkg::RUN_MAX; i++) begin
      if (3'(i) < run.count) begin
        q_mem[wr_ptr_r + PW'(i)] <= {(3'(i) == run.count - 3'd1), run.errs[i], run.chars[i]};
      end
    end
  end

  assign q_char  = q_mem[rd_ptr_r][7:0];
  assign q_err   = q_mem[rd_ptr_r][10:8];
  assign q_last  = q_mem[rd_ptr_r][11];
  assign q_count = 4'(count_r);

endmodule

// File: sv/regex_infix_to_postfix.sv
// Channel   Dir  tdata                 tuser             tlast
// in_       in   [7:0] token_char      -                 -
// out_      out  [7:0] out_char        [2:0] error_kind  last_of_run
//
// A token is taken each cycle while the result queue has room; tokens follow back to back.
// A token causes zero to four results; the output sends one result per beat,
// so input stalls only while more than four results wait in the result queue.
// A pop of the frame memory is ready for the next token through forwarding.
// Reset is synchronous and needs no clearing pass; the frame memory is not reset.
// Depends on ritp_pkg, ritp_conv, ritp_rqueue and the assertion header.
`include "regex_infix_to_postfix_assert.svh"

module regex_infix_to_postfix #(
  parameter int unsigned MAX_NEST = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] token_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic [2:0]  out_tuser,  // [2:0] error_kind
  output logic        out_tlast
);

  logic                          in_fire;
  logic                          space_ok;
  ritp_pkg::run_t                run;
  ritp_pkg::conv_status_t        status;
  logic [$clog2(MAX_NEST+1)-1:0] depth;
  logic [7:0]                    q_char;
  logic [2:0]                    q_err;
  logic [3:0]                    q_count;
  logic                          nl_fire;
  logic                          skip_fire;

  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  ritp_conv #(.MAX_NEST(MAX_NEST)) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_fire (in_fire),
    .tok_char (in_tdata),
    .run      (run),
    .status   (status),
    .depth    (depth)
  );

  ritp_rqueue u_rqueue (
    .clk      (clk),
    .rst_n    (rst_n),
    .run      (run),
    .space_ok (space_ok),
    .q_valid  (out_tvalid),
    .q_ready  (out_tready),
    .q_char   (q_char),
    .q_err    (q_err),
    .q_last   (out_tlast),
    .q_count  (q_count)
  );

  assign out_tdata = q_char;
  assign out_tuser = q_err;

  assign nl_fire   = in_fire && (in_tdata == ritp_pkg::CH_NL);
  assign skip_fire = in_fire && status.discarding;

  `RITP_ASSERT_NOW(a_queue_room, in_fire, q_count <= 4'd4, "result queue overrun")
  `RITP_ASSERT_NEXT(a_nl_ends_discard, nl_fire, !status.discarding, "newline kept discarding")
  `RITP_ASSERT_NOW(a_depth_bound, 1'b1, depth <= MAX_NEST, "nesting depth past limit")
  `RITP_ASSERT_NOW(a_discard_quiet, skip_fire, run.count == 3'd0, "skipped token gave results")

endmodule
